@@ hw/rtl/csum_pkg.sv @@
// Shared types, constants and the one's-complement add for the checksum offload block.
// No dependencies; every other file in hw/rtl except csum_fifo imports this package.
package csum_pkg;

    // IP protocol numbers that get a transport checksum.
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SHORT  = 2'd1;
    localparam logic [1:0] ST_NOT_L4 = 2'd2;
    localparam logic [1:0] ST_TRUNC  = 2'd3;

    // Smallest header length in 32-bit words, and the minimum packet length.
    localparam logic [3:0]  HWN_MIN   = 4'd5;
    localparam logic [16:0] MIN_LEN   = 17'd20;
    localparam logic [16:0] TCP_HDR   = 17'd20;
    localparam logic [16:0] UDP_HDR   = 17'd8;

    // Queue depths between the parts of the block.
    localparam int JOB_DEPTH = 4;
    localparam int RES_DEPTH = 4;
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    // Everything the back end needs to finish one packet.
    typedef struct packed {
        logic [15:0] hsum;
        logic [15:0] psum;
        logic [7:0]  pend;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [16:0] len;
        logic [5:0]  hlen;
        logic        ovf;
    } t_job;

    // One result transaction.
    typedef struct packed {
        logic [15:0] ipc;
        logic [15:0] tpc;
        logic        tcp;
        logic [1:0]  status;
    } t_result;

    // One's-complement 16-bit add with end-around carry.
    function automatic logic [15:0] fold_add(input logic [15:0] s, input logic [15:0] w);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, w};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

@@ hw/rtl/csum_fifo.sv @@
// Small generic register-based queue with occupancy count.
// Standalone; used for the job queue and the result queue.
module csum_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty,
    output logic [CW-1:0]    o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_wr;
    logic             w_rd;

    // Status and data out.
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];

    // Pointer and count update; pointers wrap at the depth.
    always_comb begin
        w_wr  = i_push & ~o_full;
        w_rd  = i_pop & ~o_empty;
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
        end
        if (w_rd) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ hw/rtl/csum_front.sv @@
// Byte-stream front end: parses the IPv4 header and keeps the running header and payload sums.
// Depends on csum_pkg; hands one job per packet to the job queue.
module csum_front import csum_pkg::*; #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_packet_byte,
    input  logic       i_last_byte,
    input  logic       i_job_full,
    output logic       o_full,
    output logic       o_job_push,
    output t_job       o_job
);

    localparam logic [15:0] MAX_POS = 16'(MAX_PACKET_BYTES);

    logic [15:0] r_pos, n_pos;
    logic [3:0]  r_hwn, n_hwn;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_src, n_src;
    logic [31:0] r_dst, n_dst;
    logic [15:0] r_hsum, n_hsum;
    logic [15:0] r_psum, n_psum;
    logic [7:0]  r_pend, n_pend;
    logic        r_ovf, n_ovf;

    logic        w_acc;
    logic        w_in_rng;
    logic [5:0]  w_hlen;
    logic        w_is_hdr;
    logic [15:0] w_rel;
    logic [7:0]  w_v;
    logic [15:0] w_word;

    assign w_acc      = i_push & ~i_job_full;
    assign o_full     = i_job_full;
    assign o_job_push = w_acc & i_last_byte;

    // Per-byte parse and sum update.
    always_comb begin
        w_in_rng = (r_pos < MAX_POS);
        n_hwn    = r_hwn;
        n_proto  = r_proto;
        n_src    = r_src;
        n_dst    = r_dst;
        n_hsum   = r_hsum;
        n_psum   = r_psum;
        n_pend   = r_pend;

        // Header length comes from the first byte, never below five words.
        if (w_in_rng && r_pos == 16'd0) begin
            n_hwn = (i_packet_byte[3:0] < HWN_MIN) ? HWN_MIN : i_packet_byte[3:0];
        end
        if (w_in_rng && r_pos == 16'd9) begin
            n_proto = i_packet_byte;
        end
        if (w_in_rng && r_pos >= 16'd12 && r_pos <= 16'd15) begin
            n_src = {r_src[23:0], i_packet_byte};
        end
        if (w_in_rng && r_pos >= 16'd16 && r_pos <= 16'd19) begin
            n_dst = {r_dst[23:0], i_packet_byte};
        end

        w_hlen   = {n_hwn, 2'b00};
        w_is_hdr = (r_pos < {10'd0, w_hlen});
        w_rel    = r_pos - {10'd0, w_hlen};

        // Checksum fields count as zero.
        w_v = i_packet_byte;
        if (w_is_hdr) begin
            if (r_pos == 16'd10 || r_pos == 16'd11) begin
                w_v = 8'd0;
            end
        end else begin
            if (n_proto == PROTO_TCP && (w_rel == 16'd16 || w_rel == 16'd17)) begin
                w_v = 8'd0;
            end
            if (n_proto == PROTO_UDP && (w_rel == 16'd6 || w_rel == 16'd7)) begin
                w_v = 8'd0;
            end
        end
        w_word = {r_pend, w_v};

        // Odd bytes complete a 16-bit word; even bytes wait for their partner.
        if (w_in_rng) begin
            if (r_pos[0]) begin
                if (w_is_hdr) begin
                    n_hsum = fold_add(r_hsum, w_word);
                end else begin
                    n_psum = fold_add(r_psum, w_word);
                end
            end else begin
                n_pend = w_v;
            end
        end

        n_ovf = r_ovf | ~w_in_rng;
        n_pos = (r_pos != 16'hffff) ? r_pos + 16'd1 : r_pos;

        // Job record for the back end, taken from the updated state.
        o_job.hsum  = n_hsum;
        o_job.psum  = n_psum;
        o_job.pend  = n_pend;
        o_job.src   = n_src;
        o_job.dst   = n_dst;
        o_job.proto = n_proto;
        o_job.len   = {1'b0, r_pos} + 17'd1;
        o_job.hlen  = w_hlen;
        o_job.ovf   = n_ovf;
    end

    // State clears on reset and after every last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hwn   <= '0;
            r_proto <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_hsum  <= '0;
            r_psum  <= '0;
            r_pend  <= '0;
            r_ovf   <= 1'b0;
        end else if (w_acc) begin
            if (i_last_byte) begin
                r_pos   <= '0;
                r_hwn   <= '0;
                r_proto <= '0;
                r_src   <= '0;
                r_dst   <= '0;
                r_hsum  <= '0;
                r_psum  <= '0;
                r_pend  <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_pos   <= n_pos;
                r_hwn   <= n_hwn;
                r_proto <= n_proto;
                r_src   <= n_src;
                r_dst   <= n_dst;
                r_hsum  <= n_hsum;
                r_psum  <= n_psum;
                r_pend  <= n_pend;
                r_ovf   <= n_ovf;
            end
        end
    end

    // A finished packet leaves the parser fully cleared.
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_last_byte) |=> (r_pos == 16'd0 && r_hsum == 16'd0 && r_psum == 16'd0))
        else $error("front state not cleared after last byte");

    // The byte position advances by one per accepted non-final byte until it saturates.
    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_last_byte && r_pos != 16'hffff) |=> (r_pos == $past(r_pos) + 16'd1))
        else $error("byte position did not advance");

endmodule

@@ hw/rtl/csum_back.sv @@
// Back end: two-stage pipeline that adds the pseudo-header, folds and sets the status.
// Depends on csum_pkg; reads the job queue and writes the result queue.
module csum_back import csum_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_empty,
    input  t_job              i_job,
    output logic              o_job_pop,
    input  logic [RES_CW-1:0] i_res_count,
    output logic              o_res_push,
    output t_result           o_res
);

    localparam int IW = RES_CW + 1;

    logic [IW-1:0] w_inflight;
    logic          w_issue;

    logic          w_tcp;
    logic          w_udp;
    logic [15:0]   w_pad;
    logic [15:0]   w_tlen;
    logic [16:0]   w_need;
    logic [1:0]    w_stat;

    logic          r_vA;
    logic [17:0]   r_sa1;
    logic [17:0]   r_sa2;
    logic [1:0]    r_statA;
    logic          r_tcpA;
    logic [15:0]   r_ipcA;

    logic [18:0]   w_tot;
    logic [16:0]   w_f1;
    logic [15:0]   w_f2;
    logic [15:0]   w_tpc;

    logic          r_vB;
    t_result       r_res;

    // Issue only when the result queue has room for everything in flight.
    assign w_inflight = {1'b0, i_res_count} + IW'(r_vA) + IW'(r_vB);
    assign w_issue    = ~i_job_empty && (w_inflight < IW'(RES_DEPTH));
    assign o_job_pop  = w_issue;

    // Stage A: status and two partial sums of the pseudo-header terms.
    always_comb begin
        w_tcp  = (i_job.proto == PROTO_TCP);
        w_udp  = (i_job.proto == PROTO_UDP);
        w_pad  = i_job.len[0] ? {i_job.pend, 8'h00} : 16'h0000;
        w_tlen = 16'(i_job.len - {11'd0, i_job.hlen});
        w_need = {11'd0, i_job.hlen} + (w_tcp ? TCP_HDR : UDP_HDR);
        if (i_job.len < MIN_LEN) begin
            w_stat = ST_SHORT;
        end else if (!w_tcp && !w_udp) begin
            w_stat = ST_NOT_L4;
        end else if (i_job.ovf || i_job.len < w_need) begin
            w_stat = ST_TRUNC;
        end else begin
            w_stat = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sa1   <= 18'(i_job.psum) + 18'(w_pad) + 18'(i_job.src[31:16])
                 + 18'(i_job.src[15:0]);
        r_sa2   <= 18'(i_job.dst[31:16]) + 18'(i_job.dst[15:0]) + 18'(i_job.proto)
                 + 18'(w_tlen);
        r_statA <= w_stat;
        r_tcpA  <= w_tcp;
        r_ipcA  <= ~i_job.hsum;
    end

    // Stage B: combine, fold twice, invert; UDP never sends a zero checksum.
    always_comb begin
        w_tot = 19'(r_sa1) + 19'(r_sa2);
        w_f1  = 17'(w_tot[15:0]) + 17'(w_tot[18:16]);
        w_f2  = w_f1[15:0] + 16'(w_f1[16]);
        w_tpc = ~w_f2;
        if (!r_tcpA && w_tpc == 16'h0000) begin
            w_tpc = 16'hffff;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.status <= r_statA;
        if (r_statA == ST_OK) begin
            r_res.ipc <= r_ipcA;
            r_res.tpc <= w_tpc;
            r_res.tcp <= r_tcpA;
        end else begin
            r_res.ipc <= '0;
            r_res.tpc <= '0;
            r_res.tcp <= 1'b0;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vA <= 1'b0;
            r_vB <= 1'b0;
        end else begin
            r_vA <= w_issue;
            r_vB <= r_vA;
        end
    end

    assign o_res_push = r_vB;
    assign o_res      = r_res;

    // The credit check keeps the result queue from ever overflowing.
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_inflight <= IW'(RES_DEPTH))
        else $error("more results in flight than result queue space");

    // Every job in stage A reaches stage B in the next cycle.
    a_stage_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vA |=> r_vB)
        else $error("stage A transaction lost");

endmodule

@@ hw/rtl/ipv4_tcp_udp_checksum_offload.sv @@
// Top level of the IPv4 header and TCP/UDP checksum offload block.
// Depends on csum_pkg, csum_front, csum_fifo and csum_back.
//
//  Channel   Direction  Handshake           Payload
//  -------   ---------  ------------------  ----------------------------------------------
//  bytes     in         push / full         i_packet_byte, i_last_byte
//  results   out        pop / empty         o_ip_header_checksum, o_transport_checksum,
//                                           o_transport_is_tcp, o_result_status
//
// One byte is accepted per cycle while full is low; the front parser's single 16-bit fold per byte sets that rate.
// After its last byte, a packet passes the job queue, the two back-end stages and the result queue write.
// Reset is synchronous and active low; it clears parser state, queues and pipeline valids.
// full rises only when the four-entry job queue is full; the back end issues a job only when
// the four-entry result queue has room for it, so a stalled pop backs up into full.
module ipv4_tcp_udp_checksum_offload import csum_pkg::*; #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_packet_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_ip_header_checksum,
    output logic [15:0] o_transport_checksum,
    output logic        o_transport_is_tcp,
    output logic [1:0]  o_result_status
);

    logic              w_job_push;
    t_job              w_job_in;
    logic              w_job_full;
    logic              w_job_empty;
    logic              w_job_pop;
    t_job              w_job_out;

    logic              w_res_push;
    t_result           w_res_in;
    t_result           w_res_out;
    logic [RES_CW-1:0] w_res_count;
    logic              w_res_full;

    // Front end: parser and running sums.
    csum_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_packet_byte (i_packet_byte),
        .i_last_byte   (i_last_byte),
        .i_job_full    (w_job_full),
        .o_full        (full),
        .o_job_push    (w_job_push),
        .o_job         (w_job_in)
    );

    // Queue between front and back.
    csum_fifo #(
        .WIDTH($bits(t_job)),
        .DEPTH(JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out),
        .o_full  (w_job_full),
        .o_empty (w_job_empty),
        .o_count ()
    );

    // Back end: pseudo-header, fold and status.
    csum_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (w_job_empty),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .i_res_count (w_res_count),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    // Result queue feeding the output ports.
    csum_fifo #(
        .WIDTH($bits(t_result)),
        .DEPTH(RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_full  (w_res_full),
        .o_empty (empty),
        .o_count (w_res_count)
    );

    assign o_ip_header_checksum = w_res_out.ipc;
    assign o_transport_checksum = w_res_out.tpc;
    assign o_transport_is_tcp   = w_res_out.tcp;
    assign o_result_status      = w_res_out.status;

    // The back end never pushes a result into a full result queue.
    a_no_res_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result pushed into full queue");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the IPv4 header and TCP/UDP checksum offload block.
// Depends on csum_pkg and ipv4_tcp_udp_checksum_offload; packets are built and predicted here.
module tb_top;
    import csum_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PKT_MAX     = 2048;
    localparam int IDLE_LIMIT  = 4000;
    localparam int BODY_BYTES  = 1340;

    // How the bytes of a directed packet are filled.
    typedef enum logic [1:0] {
        FILL_ZERO,
        FILL_ONES,
        FILL_RAND,
        FILL_UDP_NULL
    } t_fill;

    // Parser state as the block should hold it between bytes.
    typedef struct packed {
        logic [15:0] pos;
        logic [3:0]  hwn;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] hsum;
        logic [15:0] psum;
        logic [7:0]  pend;
        logic        ovf;
    } t_parser;

    // One directed packet; want is used only where typed is set.
    typedef struct {
        int          len;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        t_fill       fill;
        bit          typed;
        t_result     want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_packet_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] o_ip_header_checksum;
    logic [15:0] o_transport_checksum;
    logic        o_transport_is_tcp;
    logic [1:0]  o_result_status;

    t_parser     parser = '0;
    t_result     pending_results[$];
    t_result     oldest;
    logic [7:0]  frame[$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          pop_wait = 0;
    bit          rx_burst = 1'b0;
    bit          tx_burst = 1'b0;

    // Short packets first, then the error codes, header lengths and odd tails.
    t_dir_row directed_frames [14] = '{
        '{1,  4'd5,  PROTO_TCP, FILL_ZERO, 1'b1, '{16'h0000, 16'h0000, 1'b0, ST_SHORT}},
        '{19, 4'd15, PROTO_TCP, FILL_ONES, 1'b1, '{16'h0000, 16'h0000, 1'b0, ST_SHORT}},
        '{20, 4'd5,  8'd1,      FILL_ONES, 1'b1, '{16'h0000, 16'h0000, 1'b0, ST_NOT_L4}},
        '{20, 4'd5,  8'd0,      FILL_ZERO, 1'b1, '{16'h0000, 16'h0000, 1'b0, ST_NOT_L4}},
        '{20, 4'd5,  PROTO_UDP, FILL_RAND, 1'b1, '{16'h0000, 16'h0000, 1'b0, ST_TRUNC}},
        '{27, 4'd5,  PROTO_UDP, FILL_RAND, 1'b1, '{16'h0000, 16'h0000, 1'b0, ST_TRUNC}},
        '{28, 4'd5,  PROTO_UDP, FILL_ZERO, 1'b0, '0},
        '{39, 4'd5,  PROTO_TCP, FILL_ONES, 1'b1, '{16'h0000, 16'h0000, 1'b0, ST_TRUNC}},
        '{40, 4'd5,  PROTO_TCP, FILL_ONES, 1'b0, '0},
        '{41, 4'd5,  PROTO_TCP, FILL_RAND, 1'b0, '0},
        '{29, 4'd0,  PROTO_UDP, FILL_RAND, 1'b0, '0},
        '{80, 4'd15, PROTO_TCP, FILL_RAND, 1'b0, '0},
        '{67, 4'd15, PROTO_UDP, FILL_ONES, 1'b1, '{16'h0000, 16'h0000, 1'b0, ST_TRUNC}},
        '{30, 4'd5,  PROTO_UDP, FILL_UDP_NULL, 1'b0, '0}
    };

    ipv4_tcp_udp_checksum_offload #(
        .MAX_PACKET_BYTES(PKT_MAX)
    ) u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .push                 (push),
        .full                 (full),
        .i_packet_byte        (i_packet_byte),
        .i_last_byte          (i_last_byte),
        .empty                (empty),
        .pop                  (pop),
        .o_ip_header_checksum (o_ip_header_checksum),
        .o_transport_checksum (o_transport_checksum),
        .o_transport_is_tcp   (o_transport_is_tcp),
        .o_result_status      (o_result_status)
    );

    always #5 i_clk = ~i_clk;

    // One's-complement add: a carry out of bit 15 wraps around into bit 0.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        int unsigned t;
        t = a + b;
        if (t > 32'h0000_ffff) begin
            t = t - 32'h0000_ffff;
        end
        return t[15:0];
    endfunction

    // Advances the parser by one byte; returns 1 with the checksum result on the last byte.
    function automatic bit csum_step(inout t_parser st, input logic [7:0] b, input logic last,
                                     output t_result res);
        int unsigned p;
        int unsigned hlen;
        int unsigned len;
        int unsigned r;
        logic [7:0]  v;
        logic [15:0] s;
        res = '0;
        p = 32'(st.pos);
        if (p >= PKT_MAX) begin
            st.ovf = 1'b1;
        end else begin
            v = b;
            if (p == 0) st.hwn = (b[3:0] < HWN_MIN) ? HWN_MIN : b[3:0];
            if (p == 9) st.proto = b;
            if (p >= 12 && p <= 15) st.src = {st.src[23:0], b};
            if (p >= 16 && p <= 19) st.dst = {st.dst[23:0], b};
            hlen = st.hwn * 4;
            if (p < hlen) begin
                // The header checksum field itself counts as zero.
                if (p == 10 || p == 11) v = 8'h00;
                if (p[0]) st.hsum = ones_add(st.hsum, {st.pend, v});
                else st.pend = v;
            end else begin
                // So does the checksum field of the transport header.
                r = p - hlen;
                if (st.proto == PROTO_TCP && (r == 16 || r == 17)) v = 8'h00;
                if (st.proto == PROTO_UDP && (r == 6 || r == 7)) v = 8'h00;
                if (p[0]) st.psum = ones_add(st.psum, {st.pend, v});
                else st.pend = v;
            end
        end
        if (p < 32'h0000_ffff) st.pos = 16'(p + 1);
        if (!last) return 1'b0;

        // Last byte: classify the packet, then fold in the pseudo-header.
        len = p + 1;
        hlen = st.hwn * 4;
        if (len < 20) begin
            res.status = ST_SHORT;
        end else if (st.proto != PROTO_TCP && st.proto != PROTO_UDP) begin
            res.status = ST_NOT_L4;
        end else if (st.ovf || len < hlen + ((st.proto == PROTO_TCP) ? 20 : 8)) begin
            res.status = ST_TRUNC;
        end else begin
            res.status = ST_OK;
            res.tcp = (st.proto == PROTO_TCP);
            s = st.psum;
            if (len[0]) s = ones_add(s, {st.pend, 8'h00});
            s = ones_add(s, st.src[31:16]);
            s = ones_add(s, st.src[15:0]);
            s = ones_add(s, st.dst[31:16]);
            s = ones_add(s, st.dst[15:0]);
            s = ones_add(s, {8'h00, st.proto});
            s = ones_add(s, 16'(len - hlen));
            res.tpc = ~s;
            if (!res.tcp && res.tpc == 16'h0000) res.tpc = 16'hffff;
            res.ipc = ~st.hsum;
        end
        st = '0;
        return 1'b1;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(16, 60);
    endfunction

    // Builds a packet: the given IHL, version 4 unless the fill is random, the protocol at byte 9, filled otherwise.
    task automatic fill_frame(input int len, input logic [3:0] ihl, input logic [7:0] proto,
                              input t_fill fill);
        t_parser scratch;
        t_result r;
        bit      got;
        frame.delete();
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: frame.push_back(8'h00);
                FILL_ONES: frame.push_back(8'hff);
                default:   frame.push_back(8'($urandom));
            endcase
        end
        if (len > 0) frame[0] = (fill == FILL_RAND) ? {frame[0][7:4], ihl} : {4'h4, ihl};
        if (len > 9) frame[9] = proto;
        // Tune the first UDP payload word so that the transport checksum comes out as zero.
        if (fill == FILL_UDP_NULL && len >= 30) begin
            frame[28] = 8'h00;
            frame[29] = 8'h00;
            scratch = '0;
            got = 1'b0;
            for (int i = 0; i < len; i++) begin
                got = csum_step(scratch, frame[i], i == len - 1, r);
            end
            if (got) begin
                frame[28] = r.tpc[15:8];
                frame[29] = r.tpc[7:0];
            end
        end
    endtask

    // Random packet: mostly well formed with random content, the rest broken or noise.
    task automatic random_frame();
        int         r;
        int         ihl;
        int         need;
        int         len;
        logic [7:0] proto;
        r = $urandom_range(0, 99);
        proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
        if ($urandom_range(0, 9) == 0) ihl = $urandom_range(0, 15);
        else if ($urandom_range(0, 3) == 0) ihl = $urandom_range(5, 15);
        else ihl = 5;
        need = ((ihl < 5) ? 5 : ihl) * 4 + ((proto == PROTO_TCP) ? 20 : 8);
        if (r < 72) begin
            len = need + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 400)
                                                       : $urandom_range(0, 40));
        end else if (r < 80) begin
            len = $urandom_range(20, need - 1);
        end else if (r < 87) begin
            len = $urandom_range(1, 19);
        end else if (r < 94) begin
            len = $urandom_range(20, 80);
            do proto = 8'($urandom); while (proto == PROTO_TCP || proto == PROTO_UDP);
        end else begin
            len = $urandom_range(1, 120);
            proto = 8'($urandom);
        end
        fill_frame(len, 4'(ihl), proto, FILL_RAND);
    endtask

    // Offers one byte, waits for the transaction, and records what it should produce.
    task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                             input t_result want);
        int      gap;
        t_result got;
        gap = tx_burst ? 0 : gap_len();
        if (gap > 0) begin
            push <= 1'b0;
            i_packet_byte <= 8'($urandom);
            i_last_byte <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_packet_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (full);
        if (csum_step(parser, b, last, got)) begin
            pending_results.push_back(typed ? want : got);
        end
    endtask

    task automatic send_frame(input bit typed, input t_result want, input bit no_gaps);
        tx_burst = no_gaps || ($urandom_range(0, 4) == 0);
        for (int i = 0; i < frame.size(); i++) begin
            send_byte(frame[i], i == frame.size() - 1, typed, want);
        end
    endtask

    // Holds the sender off until every outstanding result has been read.
    task automatic drain_results();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Result side: check each popped transaction against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d", o_result_status);
                errors++;
            end else begin
                oldest = pending_results.pop_front();
                if (o_ip_header_checksum !== oldest.ipc) begin
                    $error("ip_header_checksum: expected %h, got %h",
                           oldest.ipc, o_ip_header_checksum);
                    errors++;
                end
                if (o_transport_checksum !== oldest.tpc) begin
                    $error("transport_checksum: expected %h, got %h",
                           oldest.tpc, o_transport_checksum);
                    errors++;
                end
                if (o_transport_is_tcp !== oldest.tcp) begin
                    $error("transport_is_tcp: expected %h, got %h",
                           oldest.tcp, o_transport_is_tcp);
                    errors++;
                end
                if (o_result_status !== oldest.status) begin
                    $error("result_status: expected %h, got %h",
                           oldest.status, o_result_status);
                    errors++;
                end
            end
        end
        if (pop_wait > 0) begin
            pop <= 1'b0;
            pop_wait <= pop_wait - 1;
        end else begin
            pop <= 1'b1;
            if (!rx_burst) pop_wait <= gap_len();
        end
        if ($urandom_range(0, 299) == 0) rx_burst <= !rx_burst;
    end

    // Watchdog: too long without any transaction on either side ends the run.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stimulus: reset, the directed packets, then random packets.
    initial begin
        int body_bytes;
        body_bytes = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_frames[i]) begin
            fill_frame(directed_frames[i].len, directed_frames[i].ihl,
                       directed_frames[i].proto, directed_frames[i].fill);
            send_frame(directed_frames[i].typed, directed_frames[i].want, 1'b0);
        end
        drain_results();

        while (body_bytes < BODY_BYTES) begin
            random_frame();
            body_bytes += frame.size();
            if ($urandom_range(0, 29) == 0) drain_results();
            send_frame(1'b0, '0, 1'b0);
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ ipv4_tcp_udp_checksum_offload.f @@
hw/rtl/csum_pkg.sv
hw/rtl/csum_fifo.sv
hw/rtl/csum_front.sv
hw/rtl/csum_back.sv
hw/rtl/ipv4_tcp_udp_checksum_offload.sv
sim/tb_top.sv
